// File: rtl/page_bitmap_allocator_assert.svh
// Assertion macros shared by the page bitmap allocator RTL.
// Included by files that check their own logic; no other dependencies.
`ifndef PAGE_BITMAP_ALLOCATOR_ASSERT_SVH
`define PAGE_BITMAP_ALLOCATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define PBA_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);
`define PBA_ASSERT_STEP(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) pre |=> post) \
    else $error(msg);
`else
`define PBA_ASSERT(label, clk, rst_n, prop, msg)
`define PBA_ASSERT_STEP(label, clk, rst_n, pre, post, msg)
`endif
`endif

// File: rtl/pba_pkg.sv
// Package for the page bitmap allocator: constants, codes, beat payloads,
// controller states and the command/status structs. No dependencies.
`timescale 1ns / 1ps
package pba_pkg;

  localparam int MAX_PAGES_DEF = 32768;
  localparam int PAGE_BYTES    = 4096;
  localparam int PAGE_SHIFT    = $clog2(PAGE_BYTES);
  localparam int MAX_TABLES    = 256;
  localparam int TABLE_STRIDE  = 32'h4000;
  localparam int TABLE_SHIFT   = $clog2(TABLE_STRIDE);
  localparam logic [31:0] ALIGN_MASK = 32'h0000_3fff;
  localparam int WORD_BITS     = 32;
  localparam int BIT_W         = $clog2(WORD_BITS);
  localparam int CNT_W         = 16;
  localparam int TAKEN_W       = 9;
  localparam int BLK_W         = 28 - PAGE_SHIFT;
  localparam int FIRST_W       = 32 - PAGE_SHIFT;
  localparam logic [CNT_W-1:0] PAGE_COUNT_RST = 16'd32768;

  typedef enum logic [1:0] {
    OP_FIND_FREE    = 2'd0,
    OP_FIND_ALIGNED = 2'd1,
    OP_MARK_REGION  = 2'd2,
    OP_TAKE_TABLE   = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_PAGE  = 2'd1,
    ST_NO_TABLE = 2'd2,
    ST_BEYOND   = 2'd3
  } res_status_t;

  typedef enum logic [1:0] {
    CFG_MEM_BASE   = 2'd0,
    CFG_PAGE_COUNT = 2'd1,
    CFG_POOL_START = 2'd2,
    CFG_POOL_COUNT = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    opcode_t     opcode;
    logic [31:0] base_addr;
    logic [27:0] size_bytes;
    logic [7:0]  table_index;
  } in_item_t;

  typedef struct packed {
    logic [14:0] page_index;
    logic [31:0] result_addr;
    res_status_t status;
    logic [15:0] free_pages_left;
  } out_item_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DISPATCH,
    S_SCAN,
    S_MARK_SETUP,
    S_MARK_RD,
    S_MARK_WR,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic accept;
    logic clear;
    logic dispatch;
    logic scan_run;
    logic mark_setup;
    logic mark_rd;
    logic mark_wr;
    logic commit;
  } pba_cmd_t;

  typedef struct packed {
    logic    clear_last;
    opcode_t op;
    logic    lim_zero;
    logic    scan_hit;
    logic    scan_last;
    logic    mark_none;
    logic    mark_last;
    logic    out_free;
  } pba_stat_t;

endpackage

// File: rtl/pba_if.sv
// Valid/ready channels of the page bitmap allocator: request and result.
// Depends on pba_pkg for the beat payload types.
`timescale 1ns / 1ps
interface pba_in_if import pba_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface pba_out_if import pba_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/pba_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module pba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/pba_ctrl.sv
// Controller FSM of the page bitmap allocator: sequences clear, search,
// region marking and result commit. Depends on pba_pkg and the assert header.
`timescale 1ns / 1ps
`include "page_bitmap_allocator_assert.svh"
module pba_ctrl import pba_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  pba_stat_t stat,
  output pba_cmd_t  cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        if (stat.clear_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) state_nxt = S_DISPATCH;
      end
      S_DISPATCH: begin
        unique case (stat.op)
          OP_FIND_FREE, OP_FIND_ALIGNED: begin
            state_nxt = stat.lim_zero ? S_FINISH : S_SCAN;
          end
          OP_MARK_REGION: state_nxt = S_MARK_SETUP;
          OP_TAKE_TABLE:  state_nxt = S_FINISH;
        endcase
      end
      S_SCAN: begin
        if (stat.scan_hit || stat.scan_last) state_nxt = S_FINISH;
      end
      S_MARK_SETUP: begin
        state_nxt = stat.mark_none ? S_FINISH : S_MARK_RD;
      end
      S_MARK_RD: state_nxt = S_MARK_WR;
      S_MARK_WR: begin
        state_nxt = stat.mark_last ? S_FINISH : S_MARK_RD;
      end
      S_FINISH: begin
        if (stat.out_free) state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready       = (state_r == S_IDLE);
    cmd            = '0;
    cmd.accept     = (state_r == S_IDLE) && in_valid;
    cmd.clear      = (state_r == S_CLEAR);
    cmd.dispatch   = (state_r == S_DISPATCH);
    cmd.scan_run   = (state_r == S_SCAN);
    cmd.mark_setup = (state_r == S_MARK_SETUP);
    cmd.mark_rd    = (state_r == S_MARK_RD);
    cmd.mark_wr    = (state_r == S_MARK_WR);
    cmd.commit     = (state_r == S_FINISH) && stat.out_free;
  end

  `PBA_ASSERT_STEP(a_accept_to_dispatch, clk, rst_n, in_valid && in_ready, state_r == S_DISPATCH, "accepted beat did not reach dispatch")
  `PBA_ASSERT(a_write_after_read, clk, rst_n, state_r == S_MARK_WR |-> $past(state_r) == S_MARK_RD, "bitmap write without a read")
  `PBA_ASSERT_STEP(a_hit_ends_scan, clk, rst_n, state_r == S_SCAN && stat.scan_hit, state_r == S_FINISH, "scan kept running after a hit")

endmodule

// File: rtl/pba_datapath.sv
// Datapath of the page bitmap allocator: config registers, page counters,
// bitmap RAM, word scan, region mask and result register.
// Depends on pba_pkg, pba_ram and the assert header.
`timescale 1ns / 1ps
`include "page_bitmap_allocator_assert.svh"
module pba_datapath import pba_pkg::*; #(
  parameter int MAX_PAGES = MAX_PAGES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  pba_cmd_t    cmd,
  output pba_stat_t   stat,
  input  in_item_t    in_data,
  input  logic        out_ready,
  output logic        out_valid,
  output out_item_t   out_data,
  input  logic        cfg_we,
  input  cfg_idx_t    cfg_index,
  input  logic [31:0] cfg_wdata
);

  localparam int MAP_WORDS = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
  localparam int AW        = $clog2(MAP_WORDS);
  localparam int PIDX_W    = AW + BIT_W;
  localparam logic [31:0] MAX_PAGES_32 = 32'(MAX_PAGES);
  localparam logic [WORD_BITS-1:0] ONES = {WORD_BITS{1'b1}};
  localparam logic [BIT_W-1:0] TOP_BIT = BIT_W'(WORD_BITS - 1);

  // configuration and counters
  logic [31:0]        mem_base_r;
  logic [CNT_W-1:0]   page_count_r;
  logic [31:0]        pool_start_r;
  logic [TAKEN_W-1:0] pool_count_r;
  logic [CNT_W-1:0]   used_r, used_nxt;
  logic [CNT_W-1:0]   free_r, free_nxt;
  logic [TAKEN_W-1:0] taken_r, taken_nxt;

  // current beat
  in_item_t           item_r;
  logic [FIRST_W-1:0] first_r;
  logic [BLK_W-1:0]   blocks_r;

  // clear, scan and mark sequencing
  logic [AW-1:0]        clr_word_r;
  logic [AW:0]          rd_word_r;
  logic                 chk_valid_r;
  logic [AW-1:0]        chk_word_r;
  logic [WORD_BITS-1:0] sel_mask_r;
  logic                 found_r;
  logic [PIDX_W-1:0]    found_idx_r;
  logic [CNT_W-1:0]     end_c_r;
  logic                 beyond_r;
  logic [CNT_W-1:0]     count_r;
  logic [AW-1:0]        mk_word_r;

  out_item_t out_r, out_nxt;
  logic      out_valid_r;

  // RAM ports
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic [AW-1:0]        ram_raddr;
  logic [WORD_BITS-1:0] ram_rdata;

  // combinational helpers
  logic [CNT_W-1:0]     lim;
  logic [CNT_W-1:0]     lim_m1;
  logic [31:0]          lim_m1_32;
  logic [AW-1:0]        last_word;
  logic [BIT_W-1:0]     last_bit;
  logic                 issue_ok;
  logic                 chk_last;
  logic [WORD_BITS-1:0] lim_mask;
  logic [WORD_BITS-1:0] cand;
  logic [BIT_W-1:0]     hit_bit;
  logic [WORD_BITS-1:0] align_bits;
  logic [31:0]          addr_off;
  logic [FIRST_W:0]     end_sum;
  logic [FIRST_W:0]     lim_x;
  logic [FIRST_W-1:0]   end_c_x;
  logic [FIRST_W-1:0]   span;
  logic [31:0]          first32;
  logic [31:0]          last_mk32;
  logic [AW-1:0]        first_word;
  logic [AW-1:0]        last_mk_word;
  logic [BIT_W-1:0]     lo_bit;
  logic [BIT_W-1:0]     hi_bit;
  logic [WORD_BITS-1:0] mark_mask;
  logic [CNT_W:0]       used_sum;
  logic [TAKEN_W-1:0]   pool_lim;
  logic [31:0]          found32;
  logic                 out_free;

  pba_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MAP_WORDS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign lim = ({16'b0, page_count_r} > MAX_PAGES_32) ? MAX_PAGES_32[CNT_W-1:0]
                                                      : page_count_r;
  assign lim_m1    = lim - 1'b1;
  assign lim_m1_32 = 32'(lim_m1);
  assign last_word = lim_m1_32[PIDX_W-1:BIT_W];
  assign last_bit  = lim_m1[BIT_W-1:0];

  // scan
  assign issue_ok = (rd_word_r <= {1'b0, last_word});
  assign chk_last = (chk_word_r == last_word);
  assign lim_mask = chk_last ? (ONES >> (TOP_BIT - last_bit)) : ONES;
  assign cand     = ~ram_rdata & lim_mask & sel_mask_r;

  always_comb begin
    hit_bit = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (cand[i]) hit_bit = BIT_W'(i);
    end
  end

  // word offsets are 16K-stride multiples, so alignment depends on base and bit
  always_comb begin
    logic [31:0] align_sum;
    align_sum = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      align_sum     = mem_base_r + 32'(i * PAGE_BYTES);
      align_bits[i] = ((align_sum & ALIGN_MASK) == '0);
    end
  end

  // region bounds
  assign addr_off  = in_data.base_addr - mem_base_r;
  assign end_sum   = {1'b0, first_r} + (FIRST_W + 1)'(blocks_r);
  assign lim_x     = (FIRST_W + 1)'(lim);
  assign end_c_x   = FIRST_W'(end_c_r);
  assign span      = end_c_x - first_r;
  assign first32   = 32'(first_r);
  assign last_mk32 = 32'(end_c_r - 1'b1);
  assign first_word   = first32[PIDX_W-1:BIT_W];
  assign last_mk_word = last_mk32[PIDX_W-1:BIT_W];
  assign lo_bit    = (mk_word_r == first_word) ? first_r[BIT_W-1:0] : '0;
  assign hi_bit    = (mk_word_r == last_mk_word) ? last_mk32[BIT_W-1:0] : TOP_BIT;
  assign mark_mask = (ONES << lo_bit) & (ONES >> (TOP_BIT - hi_bit));

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = mk_word_r;
    ram_wdata = ram_rdata | mark_mask;
    if (cmd.clear) begin
      ram_we    = 1'b1;
      ram_waddr = clr_word_r;
      ram_wdata = '0;
    end else if (cmd.mark_wr) begin
      ram_we = 1'b1;
    end
  end

  assign ram_raddr = cmd.scan_run ? rd_word_r[AW-1:0] : mk_word_r;

  // status to the controller
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    stat            = '0;
    stat.clear_last = (clr_word_r == AW'(MAP_WORDS - 1));
    stat.op         = item_r.opcode;
    stat.lim_zero   = (lim == '0);
    stat.scan_hit   = chk_valid_r && (cand != '0);
    stat.scan_last  = chk_valid_r && chk_last;
    stat.mark_none  = !(end_c_x > first_r);
    stat.mark_last  = (mk_word_r == last_mk_word);
    stat.out_free   = out_free;
  end

  // commit
  assign used_sum = {1'b0, used_r} + {1'b0, count_r};
  assign pool_lim = (pool_count_r > TAKEN_W'(MAX_TABLES)) ? TAKEN_W'(MAX_TABLES)
                                                          : pool_count_r;
  assign found32  = 32'(found_idx_r);

  always_comb begin
    used_nxt  = used_r;
    free_nxt  = free_r;
    taken_nxt = taken_r;
    out_nxt   = '0;
    unique case (item_r.opcode)
      OP_FIND_FREE, OP_FIND_ALIGNED: begin
        if (found_r) begin
          out_nxt.page_index  = found32[14:0];
          out_nxt.result_addr = mem_base_r + (found32 << PAGE_SHIFT);
          out_nxt.status      = ST_OK;
        end else begin
          out_nxt.status = ST_NO_PAGE;
        end
      end
      OP_MARK_REGION: begin
        used_nxt = used_sum[CNT_W] ? {CNT_W{1'b1}} : used_sum[CNT_W-1:0];
        free_nxt = (free_r > count_r) ? (free_r - count_r) : '0;
        out_nxt.result_addr = item_r.base_addr;
        out_nxt.status      = beyond_r ? ST_BEYOND : ST_OK;
      end
      OP_TAKE_TABLE: begin
        if (taken_r < pool_lim) begin
          taken_nxt           = taken_r + 1'b1;
          out_nxt.result_addr = pool_start_r
                              + (32'(item_r.table_index) << TABLE_SHIFT);
          out_nxt.status      = ST_OK;
        end else begin
          out_nxt.status = ST_NO_TABLE;
        end
      end
    endcase
    out_nxt.free_pages_left = free_nxt;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mem_base_r   <= '0;
      page_count_r <= PAGE_COUNT_RST;
      pool_start_r <= '0;
      pool_count_r <= '0;
      used_r       <= '0;
      free_r       <= PAGE_COUNT_RST;
      taken_r      <= '0;
      clr_word_r   <= '0;
      chk_valid_r  <= 1'b0;
      found_r      <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_MEM_BASE:   mem_base_r <= cfg_wdata;
          CFG_PAGE_COUNT: begin
            page_count_r <= cfg_wdata[CNT_W-1:0];
            free_r       <= cfg_wdata[CNT_W-1:0];
          end
          CFG_POOL_START: pool_start_r <= cfg_wdata;
          CFG_POOL_COUNT: pool_count_r <= cfg_wdata[TAKEN_W-1:0];
        endcase
      end
      if (cmd.clear) clr_word_r <= clr_word_r + 1'b1;
      chk_valid_r <= cmd.scan_run && issue_ok;
      if (cmd.dispatch) begin
        found_r <= 1'b0;
      end else if (cmd.scan_run && stat.scan_hit) begin
        found_r <= 1'b1;
      end
      if (cmd.commit) begin
        used_r      <= used_nxt;
        free_r      <= free_nxt;
        taken_r     <= taken_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item_r    <= in_data;
      first_r   <= addr_off[31:PAGE_SHIFT];
      blocks_r  <= in_data.size_bytes[27:PAGE_SHIFT];
      rd_word_r <= '0;
    end else if (cmd.scan_run && issue_ok) begin
      rd_word_r <= rd_word_r + 1'b1;
    end
    chk_word_r <= rd_word_r[AW-1:0];
    if (cmd.dispatch) begin
      sel_mask_r <= (item_r.opcode == OP_FIND_ALIGNED) ? align_bits : ONES;
      beyond_r   <= (blocks_r != '0) && (end_sum > lim_x);
      end_c_r    <= (end_sum > lim_x) ? lim : end_sum[CNT_W-1:0];
    end
    if (cmd.scan_run && stat.scan_hit) begin
      found_idx_r <= {chk_word_r, hit_bit};
    end
    if (cmd.mark_setup) begin
      count_r   <= stat.mark_none ? '0 : span[CNT_W-1:0];
      mk_word_r <= first_word;
    end else if (cmd.mark_wr) begin
      mk_word_r <= mk_word_r + 1'b1;
    end
    if (cmd.commit) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `PBA_ASSERT(a_free_within_count, clk, rst_n, free_r <= page_count_r, "free counter above page count")
  `PBA_ASSERT(a_found_in_limit, clk, rst_n, cmd.commit && found_r && (item_r.opcode == OP_FIND_FREE || item_r.opcode == OP_FIND_ALIGNED) |-> found32 < 32'(lim), "found page beyond limit")
  `PBA_ASSERT(a_count_matches_span, clk, rst_n, cmd.commit && item_r.opcode == OP_MARK_REGION |-> (count_r != '0) == (end_c_x > first_r), "marked page count disagrees with region")

endmodule

// File: rtl/page_bitmap_allocator.sv
// Page bitmap allocator: one used bit per page in a bitmap RAM of 32-bit
// words, a controller FSM and a datapath. After reset a clearing pass writes
// every bitmap word to zero, one word per cycle, with in_chan.ready low;
// configuration writes are taken at any time the block is idle. A search
// reads one bitmap word per cycle through the RAM read port and stops at the
// first qualifying free page or at the word holding the last page below the
// limit, limit being min(page_count, MAX_PAGES). Region marking is a
// read-modify-write of each touched word through the same RAM, with a read
// state and then a write state for each word. The result sits in an output
// register, so the next beat is accepted while a result still waits to be
// taken. Searches never mark the page they report. Depends on pba_pkg,
// pba_if, pba_ctrl and pba_datapath.
`timescale 1ns / 1ps
module page_bitmap_allocator import pba_pkg::*; #(
  parameter int MAX_PAGES = MAX_PAGES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  pba_in_if.sink      in_chan,
  pba_out_if.source   out_chan,
  input  logic        cfg_we,
  input  cfg_idx_t    cfg_index,
  input  logic [31:0] cfg_wdata
);

  pba_cmd_t  cmd;
  pba_stat_t stat;

  pba_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  pba_datapath #(
    .MAX_PAGES (MAX_PAGES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (in_chan.data),
    .out_ready (out_chan.ready),
    .out_valid (out_chan.valid),
    .out_data  (out_chan.data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

endmodule
